[rtl/core/vmd_pkg.sv]
`default_nettype none

package vmd_pkg;

  // Default sizes of the delay line and the data paths.
  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF  = 24;

  // Configuration port and register formats.
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 24;
  localparam int DEPTH_GAIN_W = 16;
  localparam int PHASE_INC_W  = 24;
  localparam logic [DEPTH_GAIN_W-1:0] DEPTH_GAIN_RST = 16'd3677;
  localparam logic [PHASE_INC_W-1:0]  PHASE_INC_RST  = 24'd3804;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEPTH_GAIN = 1'b0,
    REG_PHASE_INC  = 1'b1
  } cfg_reg_t;

  // Input item function codes.
  localparam int FUNC_W = 2;
  typedef enum logic [FUNC_W-1:0] {
    FUNC_AUDIO   = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_EMPTY   = 2'd2
  } func_t;

  // Fraction width of the delay and of all Q0.16 quantities.
  localparam int FRAC_W = 16;

  // Quarter-wave sine polynomial coefficients, Q1.16.
  localparam int SIN_W = 17;
  localparam logic [SIN_W-1:0] SIN_A = 17'd102944;
  localparam logic [SIN_W-1:0] SIN_B = 17'd42048;
  localparam logic [SIN_W-1:0] SIN_C = 17'd4640;

  // Shared serial multiplier: minimum multiplicand width, multiplier width (even).
  localparam int MUL_XW_MIN = 18;
  localparam int MUL_YW     = 18;

endpackage

`default_nettype wire

[rtl/core/vmd_if.sv]
`default_nettype none

// Input channel: function code and audio sample.
interface vmd_in_if #(
  parameter int SAMPLE_BITS = vmd_pkg::SAMPLE_BITS_DEF
);
  import vmd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output func, output sample_in, input ready);
  modport sink (input valid, input func, input sample_in, output ready);
endinterface

// Output channel: interpolated delayed sample.
interface vmd_out_if #(
  parameter int SAMPLE_BITS = vmd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[rtl/core/vibrato_modulated_delay_core.sv]
`default_nettype none

// An audio item is accepted in the idle state; its result is valid after the line reads and the interpolation product.
// A new audio item is taken only after the previous one's delay update, later if the result register is not emptied.
// The item spacing is set by the shared multiplier, which computes six products in turn.
// Command items are handled in the idle state and give no result.
// Synchronous reset empties the line by clearing its fill count; no clearing pass is needed.
module vibrato_modulated_delay_core #(
  parameter int DELAY_DEPTH = vmd_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = vmd_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = vmd_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  vmd_in_if.sink                         samples,
  vmd_out_if.source                      results
);
  import vmd_pkg::*;

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int FW     = $clog2(DELAY_DEPTH + 1);
  localparam int RDW    = AW + FRAC_W;
  localparam int MUL_XW = (SAMPLE_BITS + 1 > MUL_XW_MIN) ? SAMPLE_BITS + 1 : MUL_XW_MIN;
  localparam int PRW    = MUL_XW + MUL_YW + 2;

  localparam logic [RDW-1:0] DELAY_MAX =
    RDW'((64'(DELAY_DEPTH) - 64'd2) * 64'd65536 - 64'd1);
  localparam logic signed [PRW-1:0] ROUND_HALF = PRW'(32768);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_INTERP,
    OP_USQ,
    OP_CU,
    OP_BU,
    OP_MAG,
    OP_STEP
  } op_t;

  state_t                        state;
  op_t                           op;
  logic [AW-1:0]                 wp;
  logic [AW-1:0]                 base;
  logic [FW-1:0]                 fill;
  logic [RDW-1:0]                read_delay;
  logic [PHASE_BITS-1:0]         mod_phase;
  logic [DEPTH_GAIN_W-1:0]       depth_gain;
  logic [PHASE_INC_W-1:0]        phase_inc;
  logic [AW-1:0]                 kidx;
  logic                          va;
  logic                          vb;
  logic [FRAC_W-1:0]             frac;
  logic signed [SAMPLE_BITS-1:0] a_val;
  logic signed [SAMPLE_BITS-1:0] res_reg;
  logic [SIN_W-1:0]              u_reg;
  logic [SIN_W-1:0]              u2;
  logic                          sneg;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_data;

  logic                          in_fire;
  logic                          out_free;
  logic [AW-1:0]                 wp_inc;
  logic [AW:0]                   rdiff;
  logic [AW-1:0]                 raddr;
  logic                          ram_we;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] b_now;
  logic [PHASE_BITS+15:0]        ph_ext;
  logic [15:0]                   p16;
  logic [14:0]                   rq;
  logic [SIN_W-1:0]              u_now;
  logic                          mul_start;
  logic signed [MUL_XW-1:0]      mul_x;
  logic [MUL_YW-1:0]             mul_y;
  logic                          mul_done;
  logic signed [PRW-1:0]         mul_prod;
  logic [SIN_W-1:0]              prod_hi;
  logic signed [PRW-1:0]         isum;
  logic signed [SAMPLE_BITS-1:0] interp_res;
  logic [RDW:0]                  rd_sum;
  logic [RDW-1:0]                rd_next;

  // Zero-extend an unsigned Q1.16 quantity into the multiplicand format.
  function automatic logic signed [MUL_XW-1:0] to_x(input logic [SIN_W-1:0] v);
    return $signed(MUL_XW'(v));
  endfunction

  assign in_fire         = samples.valid && samples.ready;
  assign samples.ready   = (state == ST_IDLE);
  assign out_free        = !out_valid || results.ready;
  assign results.valid   = out_valid;
  assign results.sample_out = out_data;

  // Ring pointer step and read address behind the newest sample.
  always_comb begin
    wp_inc = (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
    rdiff  = {1'b0, base} - {1'b0, kidx};
    raddr  = rdiff[AW] ? AW'(rdiff + (AW+1)'(DELAY_DEPTH)) : rdiff[AW-1:0];
  end

  assign ram_we = in_fire && (samples.func == FUNC_AUDIO);

  vmd_delay_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (samples.sample_in),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Entries beyond the fill count read as zero.
  assign b_now = vb ? $signed(ram_rdata) : '0;

  // Fold the top 16 phase bits into a quadrant position u in Q1.16.
  always_comb begin
    ph_ext = {mod_phase, 16'b0} >> PHASE_BITS;
    p16    = ph_ext[15:0];
    rq     = 15'h4000 - {1'b0, p16[13:0]};
    u_now  = p16[14] ? {rq, 2'b00} : {1'b0, p16[13:0], 2'b00};
  end

  assign prod_hi = mul_prod[FRAC_W +: SIN_W];

  // Interpolation: a + round((b - a) * f), then saturation.
  always_comb begin
    isum = ((mul_prod + ROUND_HALF) >>> FRAC_W) + PRW'(a_val);
    if (isum > PRW'(SMP_MAX)) begin
      interp_res = SMP_MAX;
    end else if (isum < PRW'(SMP_MIN)) begin
      interp_res = SMP_MIN;
    end else begin
      interp_res = SAMPLE_BITS'(isum);
    end
  end

  // Delay update by the sine step, saturated at both ends.
  always_comb begin
    rd_sum = (RDW+1)'(read_delay) + (RDW+1)'(prod_hi);
    if (sneg) begin
      rd_next = (RDW'(prod_hi) > read_delay) ? '0 : read_delay - RDW'(prod_hi);
    end else begin
      rd_next = (rd_sum > (RDW+1)'(DELAY_MAX)) ? DELAY_MAX : RDW'(rd_sum);
    end
  end

  // Operand selection for the next product of the chain.
  always_comb begin
    mul_start = 1'b0;
    mul_x     = '0;
    mul_y     = '0;
    unique case (state)
      ST_RD_C: begin
        mul_start = 1'b1;
        mul_x     = MUL_XW'(b_now) - MUL_XW'(a_val);
        mul_y     = MUL_YW'(frac);
      end
      ST_OUT: begin
        if (out_free) begin
          mul_start = 1'b1;
          mul_x     = to_x(u_now);
          mul_y     = MUL_YW'(u_now);
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          unique case (op)
            OP_USQ: begin
              mul_start = 1'b1;
              mul_x     = to_x(SIN_C);
              mul_y     = MUL_YW'(prod_hi);
            end
            OP_CU: begin
              mul_start = 1'b1;
              mul_x     = to_x(SIN_B - prod_hi);
              mul_y     = MUL_YW'(u2);
            end
            OP_BU: begin
              mul_start = 1'b1;
              mul_x     = to_x(SIN_A - prod_hi);
              mul_y     = MUL_YW'(u_reg);
            end
            OP_MAG: begin
              mul_start = 1'b1;
              mul_x     = to_x(SIN_W'(depth_gain));
              mul_y     = MUL_YW'(prod_hi);
            end
            default: begin
              mul_start = 1'b0;
            end
          endcase
        end
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  vmd_serial_mul #(
    .XW (MUL_XW),
    .YW (MUL_YW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= OP_INTERP;
      wp         <= '0;
      fill       <= '0;
      read_delay <= '0;
      mod_phase  <= '0;
      depth_gain <= DEPTH_GAIN_RST;
      phase_inc  <= PHASE_INC_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEPTH_GAIN: depth_gain <= cfg_data[DEPTH_GAIN_W-1:0];
          REG_PHASE_INC:  phase_inc  <= cfg_data[PHASE_INC_W-1:0];
        endcase
      end

      // In the output state the register is reloaded below instead.
      if (out_valid && results.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (samples.func)
              FUNC_AUDIO: begin
                base <= wp;
                wp   <= wp_inc;
                if (fill != FW'(DELAY_DEPTH)) begin
                  fill <= fill + 1'b1;
                end
                kidx  <= AW'(read_delay[RDW-1:FRAC_W]) + 1'b1;
                frac  <= read_delay[FRAC_W-1:0];
                state <= ST_RD_A;
              end
              FUNC_RESTART: begin
                mod_phase <= '0;
              end
              FUNC_EMPTY: begin
                mod_phase  <= '0;
                fill       <= '0;
                read_delay <= '0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_RD_A: begin
          va    <= FW'(kidx) < fill;
          kidx  <= kidx + 1'b1;
          state <= ST_RD_B;
        end
        ST_RD_B: begin
          a_val <= va ? $signed(ram_rdata) : '0;
          vb    <= FW'(kidx) < fill;
          state <= ST_RD_C;
        end
        ST_RD_C: begin
          op    <= OP_INTERP;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            unique case (op)
              OP_INTERP: begin
                res_reg <= interp_res;
                state   <= ST_OUT;
              end
              OP_USQ: begin
                u2 <= prod_hi;
                op <= OP_CU;
              end
              OP_CU: op <= OP_BU;
              OP_BU: op <= OP_MAG;
              OP_MAG: op <= OP_STEP;
              OP_STEP: begin
                read_delay <= rd_next;
                mod_phase  <= mod_phase + PHASE_BITS'(phase_inc);
                state      <= ST_IDLE;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res_reg;
            u_reg     <= u_now;
            sneg      <= p16[15];
            op        <= OP_USQ;
            state     <= ST_MUL;
          end
        end
      endcase
    end
  end

  a_delay_limit: assert property (@(posedge clk) disable iff (rst) read_delay <= DELAY_MAX)
    else $error("read delay beyond the line");
  a_fill_limit: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DELAY_DEPTH))
    else $error("fill count beyond the line depth");
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wp} < (AW+1)'(DELAY_DEPTH))
    else $error("write pointer out of range");
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("product finished outside the multiply state");
  a_audio_reads: assert property (@(posedge clk) disable iff (rst)
    (in_fire && samples.func == FUNC_AUDIO) |=> state == ST_RD_A)
    else $error("audio item did not start the line reads");

endmodule

`default_nettype wire

[rtl/core/vmd_serial_mul.sv]
`default_nettype none

module vmd_serial_mul #(
  parameter int XW = vmd_pkg::MUL_XW_MIN,
  parameter int YW = vmd_pkg::MUL_YW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [XW-1:0]   x,
  input  logic [YW-1:0]          y,
  output logic                   done,
  output logic signed [XW+YW+1:0] prod
);
  localparam int ND = YW / 2;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic signed [XW+1:0] x1;
  logic signed [XW+1:0] x3;
  logic signed [XW+1:0] hi;
  logic [YW-1:0]        lo;
  logic signed [XW+2:0] addend;
  logic signed [XW+2:0] sum;

  // Multiple of the multiplicand selected by the current radix-4 digit.
  always_comb begin
    unique case (lo[1:0])
      2'd0: addend = '0;
      2'd1: addend = (XW+3)'(x1);
      2'd2: addend = (XW+3)'(x1) <<< 1;
      2'd3: addend = (XW+3)'(x3);
    endcase
    sum = (XW+3)'(hi) + addend;
  end

  // Shift-and-add: two multiplier bits retire per cycle, LSB first.
  // The partial sum shifts arithmetically so a negative multiplicand keeps its sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      hi   <= '0;
      lo   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x1   <= (XW+2)'(x);
        x3   <= (XW+2)'(x) + ((XW+2)'(x) <<< 1);
        hi   <= '0;
        lo   <= y;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= (XW+2)'(sum >>> 2);
        lo  <= {sum[1:0], lo[YW-1:2]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ND - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = $signed({hi, lo});

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done lasted more than one cycle");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("multiplier done without a running product");

endmodule

`default_nettype wire

[rtl/core/vmd_delay_ram.sv]
`default_nettype none

module vmd_delay_ram #(
  parameter int DEPTH = vmd_pkg::DELAY_DEPTH_DEF,
  parameter int WIDTH = vmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
